// ===== rtl/core/csd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the segment table for the current-to-display frame writer.
// Depends on nothing; the top level, csd_front and csd_back use it.
package csd_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int MA_W        = 12;
    localparam int SCALE_MUL   = 275;
    localparam int SCALE_SHIFT = 7;
    localparam int SCALE_PROD_W = SAMPLE_W + 9;
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;
    localparam int DIV10_PROD_W = MA_W + 16;
    localparam int BYTE_W      = 8;
    localparam int BRIGHT_W    = 3;

    localparam logic [BYTE_W-1:0] CMD_DATA    = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_ADDR    = 8'hC0;
    localparam logic [BYTE_W-1:0] CMD_CTRL    = 8'h80;
    localparam logic [BYTE_W-1:0] CTRL_ON_BIT = 8'h08;

    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_DISP_EN    = 1'b1;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic                disp_en;
    } t_disp_cfg;

    // Segment patterns for a display mounted upside down, bit order XGFEDCBA.
    function automatic logic [BYTE_W-1:0] seg_of_digit(input logic [3:0] digit);
        logic [BYTE_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h30;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h79;
            4'd4:    seg = 8'h74;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h6F;
            4'd7:    seg = 8'h38;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h7D;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/core/current_to_segment_display_frames_unit.sv =====
`timescale 1ns / 1ps
// Top level of the current-to-display frame writer: configuration registers, front end,
// queue and byte sequencer. Depends on csd_pkg, csd_front, csd_queue and csd_back.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[9:0] adc_sample
//   m_axis    out        tdata[7:0] data_byte, tuser[0] frame_start, tuser[1] frame_end,
//                        tlast last_byte
//   cfg       in         index 0 brightness, index 1 display_enable
//
// Each sample yields DIGIT_COUNT + 3 output items, one per cycle while the output is
// not stalled, issued by the byte sequencer. A sample passes through the scaling
// register, the digit pipeline, the queue and the registered output stage. Reset is
// synchronous and clears all control state.
// Output stalls back up through the two-entry queue into the digit pipeline.
module current_to_segment_display_frames_unit #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,    // [9:0] adc_sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,    // [7:0] data_byte
    output logic [1:0]  o_m_tuser,    // [0] frame_start, [1] frame_end
    output logic        o_m_tlast,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_wdata
);

    localparam int SEG_W = DIGIT_COUNT * csd_pkg::BYTE_W;

    csd_pkg::t_disp_cfg r_cfg;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_q_valid;
    logic [SEG_W-1:0]   w_front_segs;
    logic [SEG_W-1:0]   w_q_segs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= 3'd7;
            r_cfg.disp_en    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                csd_pkg::CFG_BRIGHTNESS: r_cfg.brightness <= i_cfg_wdata;
                csd_pkg::CFG_DISP_EN:    r_cfg.disp_en    <= i_cfg_wdata[0];
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    csd_front #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_sample (i_s_tdata[csd_pkg::SAMPLE_W-1:0]),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_segs   (w_front_segs),
        .i_full   (w_full)
    );

    csd_queue #(
        .WIDTH(SEG_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_segs),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_segs)
    );

    csd_back #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_segs  (w_q_segs),
        .o_q_pop   (w_pop),
        .i_cfg     (r_cfg),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser),
        .o_tlast   (o_m_tlast)
    );

endmodule

// ===== rtl/core/csd_front.sv =====
`timescale 1ns / 1ps
// Front end: scales each sample to milliamps and splits it into segment bytes, one
// digit per pipeline stage. Depends on csd_pkg.
module csd_front #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic [csd_pkg::SAMPLE_W-1:0]              i_sample,
    output logic                                      o_ready,
    output logic                                      o_push,
    output logic [DIGIT_COUNT*csd_pkg::BYTE_W-1:0]    o_segs,
    input  logic                                      i_full
);

    localparam int SEG_W = DIGIT_COUNT * csd_pkg::BYTE_W;

    logic [DIGIT_COUNT:0]              r_vld;
    logic [csd_pkg::MA_W-1:0]          r_rem [DIGIT_COUNT];
    logic [SEG_W-1:0]                  r_acc [DIGIT_COUNT+1];
    logic                              w_en;
    logic [csd_pkg::SCALE_PROD_W-1:0]  w_scaled;

    assign w_en     = !(r_vld[DIGIT_COUNT] && i_full);
    assign o_ready  = w_en;
    assign o_push   = r_vld[DIGIT_COUNT] && !i_full;
    assign o_segs   = r_acc[DIGIT_COUNT];
    assign w_scaled = csd_pkg::SCALE_PROD_W'(i_sample)
                    * csd_pkg::SCALE_PROD_W'(csd_pkg::SCALE_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DIGIT_COUNT-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0] <= w_scaled[csd_pkg::SCALE_SHIFT +: csd_pkg::MA_W];
            r_acc[0] <= '0;
        end
    end

    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
        logic [csd_pkg::DIV10_PROD_W-1:0] w_prod;
        logic [csd_pkg::MA_W-1:0]         w_quo;
        logic [csd_pkg::MA_W-1:0]         w_dig;

        assign w_prod = csd_pkg::DIV10_PROD_W'(r_rem[k])
                      * csd_pkg::DIV10_PROD_W'(csd_pkg::DIV10_MUL);
        assign w_quo  = csd_pkg::MA_W'(w_prod >> csd_pkg::DIV10_SHIFT);
        assign w_dig  = r_rem[k] - ((w_quo << 3) + (w_quo << 1));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_acc[k+1] <= r_acc[k]
                    | (SEG_W'(csd_pkg::seg_of_digit(w_dig[3:0])) << (k * csd_pkg::BYTE_W));
            end
        end

        if (k < DIGIT_COUNT - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[k+1] <= w_quo;
                end
            end
        end
    end

endmodule

// ===== rtl/core/csd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front end and the byte sequencer.
// Depends on nothing.
module csd_queue #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/csd_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the three display frames for the item at the queue head and
// drives the registered output stage. Depends on csd_pkg.
module csd_back #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_q_valid,
    input  logic [DIGIT_COUNT*csd_pkg::BYTE_W-1:0]    i_q_segs,
    output logic                                      o_q_pop,
    input  csd_pkg::t_disp_cfg                        i_cfg,
    output logic                                      o_tvalid,
    input  logic                                      i_tready,
    output logic [csd_pkg::BYTE_W-1:0]                o_tdata,
    output logic [1:0]                                o_tuser,
    output logic                                      o_tlast
);

    localparam int SEG_W    = DIGIT_COUNT * csd_pkg::BYTE_W;
    localparam int LAST_IDX = DIGIT_COUNT + 2;
    localparam int IDX_W    = $clog2(DIGIT_COUNT + 3);

    logic [IDX_W-1:0]            r_idx;
    logic                        r_tvalid;
    logic [csd_pkg::BYTE_W-1:0]  r_tdata;
    logic [1:0]                  r_tuser;
    logic                        r_tlast;
    logic                        w_load;
    logic                        w_at_last;
    logic [IDX_W-1:0]            w_seg_off;
    logic [SEG_W-1:0]            w_seg_shift;
    logic [csd_pkg::BYTE_W-1:0]  n_tdata;
    logic                        n_start;
    logic                        n_end;
    logic                        n_last;

    assign w_load      = i_q_valid && (!r_tvalid || i_tready);
    assign w_at_last   = (r_idx == IDX_W'(LAST_IDX));
    assign o_q_pop     = w_load && w_at_last;
    assign w_seg_off   = r_idx - IDX_W'(2);
    assign w_seg_shift = i_q_segs >> {w_seg_off, 3'b000};

    always_comb begin
        n_tdata = w_seg_shift[csd_pkg::BYTE_W-1:0];
        n_start = 1'b0;
        n_end   = (r_idx == IDX_W'(LAST_IDX - 1));
        n_last  = 1'b0;
        if (r_idx == IDX_W'(0)) begin
            n_tdata = csd_pkg::CMD_DATA;
            n_start = 1'b1;
            n_end   = 1'b1;
        end else if (r_idx == IDX_W'(1)) begin
            n_tdata = csd_pkg::CMD_ADDR;
            n_start = 1'b1;
            n_end   = 1'b0;
        end else if (w_at_last) begin
            n_tdata = csd_pkg::CMD_CTRL
                    | (i_cfg.disp_en ? csd_pkg::CTRL_ON_BIT : '0)
                    | csd_pkg::BYTE_W'(i_cfg.brightness);
            n_start = 1'b1;
            n_end   = 1'b1;
            n_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_tvalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_tvalid <= 1'b1;
                r_idx    <= w_at_last ? '0 : r_idx + IDX_W'(1);
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= n_tdata;
            r_tuser <= {n_end, n_start};
            r_tlast <= n_last;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

// ===== rtl/core/csd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the frame sequence of the current-to-display frame writer,
// bound to the top level. Depends on current_to_segment_display_frames_unit.
module csd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser,
    input logic       o_m_tlast
);

    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_m_tvalid && i_m_tready) begin
            r_first <= o_m_tlast;
        end
    end

    a_first_is_data_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_first |-> o_m_tdata == 8'h40 && o_m_tuser == 2'b11 && !o_m_tlast)
        else $error("run does not open with the data command");

    a_last_is_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == 2'b11 && o_m_tdata[7:4] == 4'h8)
        else $error("final item is not a lone control command");

    a_addr_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == 2'b01 |-> o_m_tdata == 8'hC0)
        else $error("address frame opens with a wrong byte");

    a_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> !o_m_tlast && !o_m_tdata[7])
        else $error("segment item malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output item changed");

endmodule

bind current_to_segment_display_frames_unit csd_checker u_csd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
